// ===== sv/cbc_pkg.sv =====
`timescale 1ns / 1ps

package cbc_pkg;

  // bank register widths of the attached cartridge
  localparam int unsigned ROM_BANK_BITS = 9;
  localparam int unsigned RAM_BANK_BITS = 4;

  localparam logic [8:0] RomBankMask = 9'((10'd1 << ROM_BANK_BITS) - 10'd1);
  localparam logic [3:0] RamBankMask = 4'((5'd1 << RAM_BANK_BITS) - 5'd1);

  // clock register count and counter limits
  localparam int unsigned ClockRegs  = 5;
  localparam logic [8:0]  SecLimit   = 9'd60;
  localparam logic [8:0]  MinLimit   = 9'd60;
  localparam logic [8:0]  HourLimit  = 9'd24;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_ROM   = 2'd1,
    TGT_RAM   = 2'd2,
    TGT_CLOCK = 2'd3
  } target_e;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_MBC1 = 3'd1,
    KIND_MBC2 = 3'd2,
    KIND_MBC3 = 3'd3,
    KIND_MBC5 = 3'd4
  } kind_e;

  // clock register indexes
  typedef enum logic [2:0] {
    CLK_SEC     = 3'd0,
    CLK_MIN     = 3'd1,
    CLK_HOUR    = 3'd2,
    CLK_DAY_LO  = 3'd3,
    CLK_DAY_HI  = 3'd4
  } clk_reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } cbc_in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [22:0] mem_address;
    logic        write_enable;
    logic [7:0]  write_data;
    logic [7:0]  clock_data;
  } cbc_out_t;

  // commands from the mapper to the clock unit
  typedef struct packed {
    logic       tick;
    logic       wr;
    logic       latch;
    logic [2:0] idx;
    logic [7:0] data;
  } rtc_ctl_t;

endpackage

// ===== sv/cartridge_bank_controller.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_stall_o | in_item_i   (cbc_in_t)
// out     | out | out_valid_o/out_stall_i | out_item_o (cbc_out_t)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (mapper kind)
//
// one access per clock while the output is not stalled; a result reaches the output
// through the input register, then bank translation into the result register
// reset sets the low ROM bank to 1 and clears the other bank registers, the clock registers and the mapper kind
// a stall on the output holds both stages and is passed to in_stall_o
// the configuration port is always ready

module cartridge_bank_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbc_pkg::cbc_in_t   in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbc_pkg::cbc_out_t  out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i
);

  logic              in_vld_q;
  cbc_pkg::cbc_in_t  in_item_q;
  logic              out_vld_q;
  cbc_pkg::cbc_out_t out_item_q;
  logic              advance;
  logic              load_in;
  cbc_pkg::rtc_ctl_t rtc_ctl;
  cbc_pkg::cbc_out_t result;
  logic [7:0]        clock_rd;

  // pipeline flow control
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign load_in     = !in_vld_q || advance;
  assign in_stall_o  = !load_in;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load_in) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  cbc_mapper u_mapper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (advance),
    .item_i      (in_item_q),
    .clock_rd_i  (clock_rd),
    .rtc_ctl_o   (rtc_ctl),
    .result_o    (result)
  );

  cbc_rtc u_rtc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (rtc_ctl),
    .latched_o (clock_rd)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== sv/cbc_rtc.sv =====
`timescale 1ns / 1ps

module cbc_rtc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbc_pkg::rtc_ctl_t  ctl_i,
  output logic [7:0]         latched_o
);

  logic [7:0] live_q [cbc_pkg::ClockRegs];
  logic [7:0] live_d [cbc_pkg::ClockRegs];
  logic [7:0] latch_q [cbc_pkg::ClockRegs];
  logic [7:0] latch_d [cbc_pkg::ClockRegs];

  logic [8:0] sec_inc, min_inc, hour_inc;
  logic       sec_wrap, min_wrap, hour_wrap;

  // counter increments and overflow
  assign sec_inc   = {1'b0, live_q[cbc_pkg::CLK_SEC]} + 9'd1;
  assign min_inc   = {1'b0, live_q[cbc_pkg::CLK_MIN]} + 9'd1;
  assign hour_inc  = {1'b0, live_q[cbc_pkg::CLK_HOUR]} + 9'd1;
  assign sec_wrap  = sec_inc >= cbc_pkg::SecLimit;
  assign min_wrap  = min_inc >= cbc_pkg::MinLimit;
  assign hour_wrap = hour_inc >= cbc_pkg::HourLimit;

  // next value of live and latched copies
  always_comb begin
    live_d  = live_q;
    latch_d = latch_q;
    if (ctl_i.tick && !live_q[cbc_pkg::CLK_DAY_HI][6]) begin
      live_d[cbc_pkg::CLK_SEC] = sec_wrap ? 8'd0 : sec_inc[7:0];
      if (sec_wrap) begin
        live_d[cbc_pkg::CLK_MIN] = min_wrap ? 8'd0 : min_inc[7:0];
        if (min_wrap) begin
          live_d[cbc_pkg::CLK_HOUR] = hour_wrap ? 8'd0 : hour_inc[7:0];
          if (hour_wrap) begin
            if (live_q[cbc_pkg::CLK_DAY_LO] != 8'hFF) begin
              live_d[cbc_pkg::CLK_DAY_LO] = live_q[cbc_pkg::CLK_DAY_LO] + 8'd1;
            end else begin
              live_d[cbc_pkg::CLK_DAY_LO] = 8'd0;
              if (!live_q[cbc_pkg::CLK_DAY_HI][0]) begin
                live_d[cbc_pkg::CLK_DAY_HI] = live_q[cbc_pkg::CLK_DAY_HI] | 8'h01;
              end else begin
                live_d[cbc_pkg::CLK_DAY_HI] = (live_q[cbc_pkg::CLK_DAY_HI] | 8'h80) & 8'hFE;
              end
            end
          end
        end
      end
    end
    if (ctl_i.latch) begin
      latch_d = live_q;
    end
    if (ctl_i.wr && (ctl_i.idx < 3'(cbc_pkg::ClockRegs))) begin
      live_d[ctl_i.idx]  = ctl_i.data;
      latch_d[ctl_i.idx] = ctl_i.data;
    end
  end

  // clock register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbc_pkg::ClockRegs; i++) begin
        live_q[i]  <= 8'd0;
        latch_q[i] <= 8'd0;
      end
    end else begin
      live_q  <= live_d;
      latch_q <= latch_d;
    end
  end

  // latched copy read port
  assign latched_o = (ctl_i.idx < 3'(cbc_pkg::ClockRegs)) ? latch_q[ctl_i.idx] : 8'd0;

endmodule

// ===== sv/cbc_mapper.sv =====
`timescale 1ns / 1ps

module cbc_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_write_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               fire_i,
  input  cbc_pkg::cbc_in_t   item_i,
  input  logic [7:0]         clock_rd_i,
  output cbc_pkg::rtc_ctl_t  rtc_ctl_o,
  output cbc_pkg::cbc_out_t  result_o
);

  logic [2:0] kind_q;
  logic [7:0] rom_low_q, rom_low_d;
  logic [1:0] rom_high_q, rom_high_d;
  logic [3:0] ram_sel_q, ram_sel_d;
  logic       mode_q, mode_d;
  logic       clk_sel_q, clk_sel_d;
  logic [2:0] clk_idx_q, clk_idx_d;
  logic       latch_last_q, latch_last_d;

  logic [15:0] addr;
  logic [7:0]  data;
  logic        is_write, is_read, is_tick;
  logic        in_ram_win, clock_active;
  logic [8:0]  upper_bank, lower_bank;
  logic [3:0]  ram_page;
  logic [22:0] rom_addr_lo, rom_addr_hi, ram_addr;

  assign addr     = item_i.bus_address;
  assign data     = item_i.bus_data;
  assign is_write = fire_i && (item_i.func == cbc_pkg::FUNC_WRITE);
  assign is_read  = item_i.func == cbc_pkg::FUNC_READ;
  assign is_tick  = fire_i && (item_i.func == cbc_pkg::FUNC_TICK);
  assign in_ram_win = addr[15:13] == 3'b101;

  assign clock_active = (kind_q == cbc_pkg::KIND_MBC3) && clk_sel_q &&
                        (clk_idx_q < 3'(cbc_pkg::ClockRegs));

  // bank selection per mapper kind
  always_comb begin
    upper_bank = 9'd1;
    lower_bank = 9'd0;
    ram_page   = 4'd0;
    case (kind_q)
      cbc_pkg::KIND_MBC1: begin
        upper_bank = {2'b00, rom_high_q,
                      (rom_low_q[4:0] == 5'd0) ? 5'd1 : rom_low_q[4:0]};
        if (mode_q) begin
          lower_bank = {2'b00, rom_high_q, 5'd0};
          ram_page   = {2'b00, rom_high_q};
        end
      end
      cbc_pkg::KIND_MBC2: begin
        upper_bank = {5'd0, (rom_low_q[3:0] == 4'd0) ? 4'd1 : rom_low_q[3:0]};
      end
      cbc_pkg::KIND_MBC3: begin
        upper_bank = {2'b00, (rom_low_q[6:0] == 7'd0) ? 7'd1 : rom_low_q[6:0]};
        ram_page   = {2'b00, ram_sel_q[1:0]};
      end
      cbc_pkg::KIND_MBC5: begin
        upper_bank = {rom_high_q[0], rom_low_q};
        ram_page   = ram_sel_q;
      end
      default: begin
        upper_bank = 9'd1;
      end
    endcase
  end

  // physical addresses
  assign rom_addr_lo = {lower_bank & cbc_pkg::RomBankMask, addr[13:0]};
  assign rom_addr_hi = {upper_bank & cbc_pkg::RomBankMask, addr[13:0]};
  assign ram_addr    = {6'd0, ram_page & cbc_pkg::RamBankMask, addr[12:0]};

  // bank command decode
  always_comb begin
    rom_low_d    = rom_low_q;
    rom_high_d   = rom_high_q;
    ram_sel_d    = ram_sel_q;
    mode_d       = mode_q;
    clk_sel_d    = clk_sel_q;
    clk_idx_d    = clk_idx_q;
    latch_last_d = latch_last_q;
    rtc_ctl_o    = '0;
    rtc_ctl_o.idx  = clk_idx_q;
    rtc_ctl_o.data = data;
    rtc_ctl_o.tick = is_tick && (kind_q == cbc_pkg::KIND_MBC3);
    if (is_write && !addr[15] && (addr[14:13] != 2'b00)) begin
      case (kind_q)
        cbc_pkg::KIND_MBC1: begin
          case (addr[14:13])
            2'b01:   rom_low_d  = {3'd0, (data[4:0] == 5'd0) ? 5'd1 : data[4:0]};
            2'b10:   rom_high_d = data[1:0];
            default: mode_d     = data[0];
          endcase
        end
        cbc_pkg::KIND_MBC2: begin
          if (addr[14:13] == 2'b01) begin
            rom_low_d = {4'd0, (data[3:0] == 4'd0) ? 4'd1 : data[3:0]};
          end
        end
        cbc_pkg::KIND_MBC3: begin
          case (addr[14:13])
            2'b01: rom_low_d = {1'b0, (data[6:0] == 7'd0) ? 7'd1 : data[6:0]};
            2'b10: begin
              if (data inside {[8'd0 : 8'd3]}) begin
                ram_sel_d = data[3:0];
                clk_sel_d = 1'b0;
              end else if (data inside {[8'd8 : 8'd12]}) begin
                clk_idx_d = 3'(data - 8'd8);
                clk_sel_d = 1'b1;
              end
            end
            default: begin
              rtc_ctl_o.latch = !latch_last_q && data[0];
              latch_last_d    = data[0];
            end
          endcase
        end
        cbc_pkg::KIND_MBC5: begin
          if (addr[14:12] == 3'b010) begin
            rom_low_d = data;
          end else if (addr[14:13] == 2'b01) begin
            rom_high_d = {1'b0, data[0]};
          end else if (addr[14:13] == 2'b10) begin
            ram_sel_d = data[3:0];
          end
        end
        default: begin
          rom_low_d = rom_low_q;
        end
      endcase
    end
    if (is_write && in_ram_win && clock_active) begin
      rtc_ctl_o.wr = 1'b1;
    end
  end

  // result of the access
  always_comb begin
    result_o = '0;
    if (item_i.func == cbc_pkg::FUNC_WRITE) begin
      if (in_ram_win) begin
        if (clock_active) begin
          result_o.target = cbc_pkg::TGT_CLOCK;
        end else begin
          result_o.target       = cbc_pkg::TGT_RAM;
          result_o.mem_address  = ram_addr;
          result_o.write_enable = 1'b1;
          result_o.write_data   = data;
        end
      end
    end else if (is_read) begin
      if (!addr[15]) begin
        result_o.target      = cbc_pkg::TGT_ROM;
        result_o.mem_address = addr[14] ? rom_addr_hi : rom_addr_lo;
      end else if (in_ram_win) begin
        if (clock_active) begin
          result_o.target     = cbc_pkg::TGT_CLOCK;
          result_o.clock_data = clock_rd_i;
        end else begin
          result_o.target      = cbc_pkg::TGT_RAM;
          result_o.mem_address = ram_addr;
        end
      end
    end
  end

  // mapper kind register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= cbc_pkg::KIND_NONE;
    end else if (cfg_write_i) begin
      kind_q <= cfg_data_i;
    end
  end

  // bank state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_low_q    <= 8'd1;
      rom_high_q   <= 2'd0;
      ram_sel_q    <= 4'd0;
      mode_q       <= 1'b0;
      clk_sel_q    <= 1'b0;
      clk_idx_q    <= cbc_pkg::CLK_SEC;
      latch_last_q <= 1'b0;
    end else begin
      rom_low_q    <= rom_low_d;
      rom_high_q   <= rom_high_d;
      ram_sel_q    <= ram_sel_d;
      mode_q       <= mode_d;
      clk_sel_q    <= clk_sel_d;
      clk_idx_q    <= clk_idx_d;
      latch_last_q <= latch_last_d;
    end
  end

endmodule

// ===== tb/tb_cartridge_bank_controller.sv =====
`timescale 1ns / 1ps

import cbc_pkg::*;

// cartridge bus regions and command windows
localparam logic [15:0] CMD_BASE       = 16'h2000;
localparam logic [15:0] MBC5_HIGH_BASE = 16'h3000;
localparam logic [15:0] HIGH_BASE      = 16'h4000;
localparam logic [15:0] MODE_BASE      = 16'h6000;
localparam logic [15:0] ROM_END        = 16'h8000;
localparam logic [15:0] RAM_BASE       = 16'hA000;
localparam logic [15:0] RAM_END        = 16'hC000;
localparam logic [15:0] WINDOW_SPAN    = 16'h1FFF;

// bank select values on the clock mapper
localparam logic [7:0] RAM_SEL_LAST  = 8'h03;
localparam logic [7:0] RTC_SEL_FIRST = 8'h08;
localparam logic [7:0] RTC_SEL_LAST  = 8'h0C;

// day high register bits
localparam int DAY_MSB_BIT = 0;
localparam int HALT_BIT    = 6;
localparam int CARRY_BIT   = 7;

// function code with no meaning and mapper kinds outside the known set
localparam logic [1:0] FUNC_UNUSED    = 2'd3;
localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

// bank mapper state and the queue of translations still to come out
class cart_mapper_model;
  logic [2:0] mapper_kind;
  logic [7:0] bank_low;
  logic [1:0] bank_high;
  logic [3:0] ram_sel;
  logic       mode;
  logic       rtc_sel;
  logic [2:0] rtc_idx;
  logic       latch_prev;
  logic [7:0] rtc_live    [ClockRegs];
  logic [7:0] rtc_latched [ClockRegs];
  cbc_out_t   pending_results [$];
  int unsigned errors;

  function new();
    mapper_kind = KIND_NONE;
    bank_low    = 8'd1;
    bank_high   = '0;
    ram_sel     = '0;
    mode        = 1'b0;
    rtc_sel     = 1'b0;
    rtc_idx     = '0;
    latch_prev  = 1'b0;
    foreach (rtc_live[i]) begin
      rtc_live[i]    = '0;
      rtc_latched[i] = '0;
    end
    errors = 0;
  endfunction

  // bank 0 reads as bank 1
  function logic [7:0] nonzero(logic [7:0] b);
    return (b == 8'd0) ? 8'd1 : b;
  endfunction

  function logic [8:0] upper_bank();
    logic [8:0] b;
    logic [7:0] n;
    case (mapper_kind)
      KIND_MBC1: begin
        n = nonzero({3'b000, bank_low[4:0]});
        b = {2'b00, bank_high, n[4:0]};
      end
      KIND_MBC2: begin
        n = nonzero({4'b0000, bank_low[3:0]});
        b = {1'b0, n};
      end
      KIND_MBC3: begin
        n = nonzero({1'b0, bank_low[6:0]});
        b = {1'b0, n};
      end
      KIND_MBC5: b = {bank_high[0], bank_low};
      default:   b = 9'd1;
    endcase
    return b & RomBankMask;
  endfunction

  function logic [8:0] lower_bank();
    if (mapper_kind == KIND_MBC1 && mode) begin
      return {2'b00, bank_high, 5'b00000} & RomBankMask;
    end
    return '0;
  endfunction

  function logic [3:0] ram_page();
    logic [3:0] b;
    case (mapper_kind)
      KIND_MBC1: b = mode ? {2'b00, bank_high} : 4'd0;
      KIND_MBC3: b = {2'b00, ram_sel[1:0]};
      KIND_MBC5: b = ram_sel;
      default:   b = 4'd0;
    endcase
    return b & RamBankMask;
  endfunction

  function logic rtc_active();
    return mapper_kind == KIND_MBC3 && rtc_sel && rtc_idx < ClockRegs;
  endfunction

  // writes to the ROM area at or above CMD_BASE are mapper commands
  function void bank_command(logic [15:0] a, logic [7:0] v);
    if (a < CMD_BASE) return;
    case (mapper_kind)
      KIND_MBC1: begin
        if (a < HIGH_BASE) bank_low = nonzero({3'b000, v[4:0]});
        else if (a < MODE_BASE) bank_high = v[1:0];
        else mode = v[0];
      end
      KIND_MBC2: begin
        if (a < HIGH_BASE) bank_low = nonzero({4'b0000, v[3:0]});
      end
      KIND_MBC3: begin
        if (a < HIGH_BASE) begin
          bank_low = nonzero({1'b0, v[6:0]});
        end else if (a < MODE_BASE) begin
          if (v <= RAM_SEL_LAST) begin
            ram_sel = v[3:0];
            rtc_sel = 1'b0;
          end else if (v >= RTC_SEL_FIRST && v <= RTC_SEL_LAST) begin
            rtc_idx = 3'(v - RTC_SEL_FIRST);
            rtc_sel = 1'b1;
          end
        end else begin
          // rising edge of bit 0 snapshots the live clock
          if (!latch_prev && v[0]) rtc_latched = rtc_live;
          latch_prev = v[0];
        end
      end
      KIND_MBC5: begin
        if (a < MBC5_HIGH_BASE) bank_low = v;
        else if (a < HIGH_BASE) bank_high = {1'b0, v[0]};
        else if (a < MODE_BASE) ram_sel = v[3:0];
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the counter wraps and carries into the next one
  function logic count_up(int idx, logic [8:0] limit);
    logic [8:0] n;
    n = {1'b0, rtc_live[idx]} + 9'd1;
    if (n < limit) begin
      rtc_live[idx] = n[7:0];
      return 1'b0;
    end
    rtc_live[idx] = '0;
    return 1'b1;
  endfunction

  function void advance_clock();
    if (mapper_kind != KIND_MBC3 || rtc_live[CLK_DAY_HI][HALT_BIT]) return;
    if (!count_up(CLK_SEC, SecLimit)) return;
    if (!count_up(CLK_MIN, MinLimit)) return;
    if (!count_up(CLK_HOUR, HourLimit)) return;
    if (rtc_live[CLK_DAY_LO] != 8'hFF) begin
      rtc_live[CLK_DAY_LO] = rtc_live[CLK_DAY_LO] + 8'd1;
    end else begin
      rtc_live[CLK_DAY_LO] = '0;
      if (!rtc_live[CLK_DAY_HI][DAY_MSB_BIT]) begin
        rtc_live[CLK_DAY_HI][DAY_MSB_BIT] = 1'b1;
      end else begin
        rtc_live[CLK_DAY_HI][DAY_MSB_BIT] = 1'b0;
        rtc_live[CLK_DAY_HI][CARRY_BIT]   = 1'b1;
      end
    end
  endfunction

  // translate one accepted access and queue its result
  function void note_access(cbc_in_t item);
    cbc_out_t   r;
    logic [15:0] a;
    logic [7:0]  v;
    r = '0;
    a = item.bus_address;
    v = item.bus_data;
    case (item.func)
      FUNC_WRITE: begin
        if (a < ROM_END) begin
          bank_command(a, v);
        end else if (a >= RAM_BASE && a < RAM_END) begin
          if (rtc_active()) begin
            rtc_live[rtc_idx]    = v;
            rtc_latched[rtc_idx] = v;
            r.target = TGT_CLOCK;
          end else begin
            r.target       = TGT_RAM;
            r.mem_address  = {6'b000000, ram_page(), a[12:0]};
            r.write_enable = 1'b1;
            r.write_data   = v;
          end
        end
      end
      FUNC_READ: begin
        if (a < HIGH_BASE) begin
          r.target      = TGT_ROM;
          r.mem_address = {lower_bank(), a[13:0]};
        end else if (a < ROM_END) begin
          r.target      = TGT_ROM;
          r.mem_address = {upper_bank(), a[13:0]};
        end else if (a >= RAM_BASE && a < RAM_END) begin
          if (rtc_active()) begin
            r.target     = TGT_CLOCK;
            r.clock_data = rtc_latched[rtc_idx];
          end else begin
            r.target      = TGT_RAM;
            r.mem_address = {6'b000000, ram_page(), a[12:0]};
          end
        end
      end
      FUNC_TICK: advance_clock();
      default: ;
    endcase
    pending_results = {pending_results, r};
  endfunction

  function void check_result(cbc_out_t got);
    cbc_out_t want;
    if (pending_results.size() == 0) begin
      $error("result with no access outstanding: %0h", got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.target !== want.target) begin
      $error("target: expected %0d, got %0d", want.target, got.target);
      errors++;
    end
    if (got.mem_address !== want.mem_address) begin
      $error("mem_address: expected %0h, got %0h", want.mem_address, got.mem_address);
      errors++;
    end
    if (got.write_enable !== want.write_enable) begin
      $error("write_enable: expected %0d, got %0d", want.write_enable, got.write_enable);
      errors++;
    end
    if (got.write_data !== want.write_data) begin
      $error("write_data: expected %0h, got %0h", want.write_data, got.write_data);
      errors++;
    end
    if (got.clock_data !== want.clock_data) begin
      $error("clock_data: expected %0h, got %0h", want.clock_data, got.clock_data);
      errors++;
    end
  endfunction
endclass

module tb_cartridge_bank_controller;

  localparam int PHASE_ITEMS   = 55;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  cbc_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cbc_out_t out_item_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [2:0] cfg_data_i = KIND_NONE;

  cart_mapper_model model = new();

  logic gaps_on  = 1'b1;
  logic stall_on = 1'b1;
  int   items_sent  = 0;
  int   stall_left  = 0;
  int   cycle_count = 0;

  logic [2:0] phase_kinds [11] = '{KIND_MBC1, KIND_MBC3, KIND_NONE, KIND_MBC2, KIND_MBC5,
                                   KIND_UNUSED_HI, KIND_MBC3, KIND_MBC1, KIND_UNUSED_LO,
                                   KIND_MBC5, KIND_MBC3};

  cartridge_bank_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output back-pressure: mostly short bursts, now and then a long one
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!stall_on || $urandom_range(0, 99) < 70) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end
  end

  // check results before noting new transfers so the same edge stays ordered
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) model.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) model.note_access(in_item_i);
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] in_window(logic [15:0] base);
    return base | 16'($urandom_range(0, WINDOW_SPAN));
  endfunction

  // preset values that roll over within a tick or two; day high gets a random value, mostly not halted
  function automatic logic [7:0] near_rollover(int idx);
    logic [7:0] v;
    case (idx)
      CLK_SEC:    v = 8'(SecLimit - 9'($urandom_range(1, 2)));
      CLK_MIN:    v = 8'(MinLimit - 9'($urandom_range(1, 2)));
      CLK_HOUR:   v = 8'(HourLimit - 9'($urandom_range(1, 2)));
      CLK_DAY_LO: v = 8'hFF - 8'($urandom_range(0, 1));
      default: begin
        v = 8'($urandom);
        if ($urandom_range(0, 4) != 0) v[HALT_BIT] = 1'b0;
      end
    endcase
    return v;
  endfunction

  task automatic send_access(cbc_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic bus_op(logic [1:0] f, logic [15:0] a, logic [7:0] d);
    cbc_in_t item;
    item.func        = f;
    item.bus_address = a;
    item.bus_data    = d;
    send_access(item);
  endtask

  // hold the sender until every outstanding result has drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_kind(logic [2:0] k);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model.mapper_kind = k;
  endtask

  // one random access, weighted toward meaningful commands and windows
  task automatic rand_access(logic [2:0] kind);
    int pick;
    logic [1:0]  window;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    d    = 8'($urandom);
    if (pick < 30) begin
      window = 2'($urandom);
      a      = {1'b0, window, 13'($urandom)};
      if (kind == KIND_MBC3 && a >= HIGH_BASE && a < MODE_BASE) begin
        case ($urandom_range(0, 2))
          0: d = 8'($urandom_range(0, RAM_SEL_LAST));
          1: d = 8'($urandom_range(RTC_SEL_FIRST, RTC_SEL_LAST));
          default: ;
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        d = 8'h00;
      end
      bus_op(FUNC_WRITE, a, d);
    end else if (pick < 55) begin
      bus_op(FUNC_READ, {1'b0, 15'($urandom)}, d);
    end else if (pick < 72) begin
      bus_op(FUNC_READ, in_window(RAM_BASE), d);
    end else if (pick < 82) begin
      bus_op(FUNC_WRITE, in_window(RAM_BASE), d);
    end else if (pick < 90) begin
      bus_op(FUNC_TICK, 16'($urandom), d);
    end else begin
      bus_op(2'($urandom), 16'($urandom), d);
    end
  endtask

  // preset the clock, tick, latch, then read back every register
  task automatic clock_session();
    logic [7:0] v;
    for (int i = 0; i < ClockRegs; i++) begin
      bus_op(FUNC_WRITE, in_window(HIGH_BASE), RTC_SEL_FIRST + 8'(i));
      v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : near_rollover(i);
      bus_op(FUNC_WRITE, in_window(RAM_BASE), v);
    end
    repeat ($urandom_range(1, 4)) bus_op(FUNC_TICK, 16'($urandom), 8'($urandom));
    bus_op(FUNC_WRITE, in_window(MODE_BASE), {7'($urandom), 1'b0});
    bus_op(FUNC_WRITE, in_window(MODE_BASE), {7'($urandom), 1'b1});
    for (int i = 0; i < ClockRegs; i++) begin
      bus_op(FUNC_WRITE, in_window(HIGH_BASE), RTC_SEL_FIRST + 8'(i));
      bus_op(FUNC_READ, in_window(RAM_BASE), 8'($urandom));
    end
    if ($urandom_range(0, 1) == 0) begin
      bus_op(FUNC_WRITE, in_window(HIGH_BASE), 8'($urandom_range(0, RAM_SEL_LAST)));
      bus_op(FUNC_READ, in_window(RAM_BASE), 8'($urandom));
    end
  endtask

  initial begin
    int start;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no mapper: fixed banks, commands ignored, unmapped area
    bus_op(FUNC_READ,  16'h0000, 8'h00);
    bus_op(FUNC_READ,  16'h7FFF, 8'hFF);
    bus_op(FUNC_WRITE, 16'hBFFF, 8'hFF);
    bus_op(FUNC_READ,  16'hFFFF, 8'h00);
    bus_op(FUNC_WRITE, CMD_BASE, 8'h05);
    bus_op(FUNC_UNUSED, RAM_BASE, 8'hA5);

    // mbc1: zero bank, upper bits, mode 1 remaps lower window and ram
    set_kind(KIND_MBC1);
    bus_op(FUNC_WRITE, CMD_BASE,  8'h00);
    bus_op(FUNC_WRITE, HIGH_BASE, 8'h03);
    bus_op(FUNC_WRITE, MODE_BASE, 8'h01);
    bus_op(FUNC_READ,  16'h0000,  8'h00);
    bus_op(FUNC_READ,  HIGH_BASE, 8'h00);
    bus_op(FUNC_READ,  RAM_BASE,  8'h00);

    // mbc2: low nibble of zero
    set_kind(KIND_MBC2);
    bus_op(FUNC_WRITE, 16'h2100, 8'h10);
    bus_op(FUNC_READ,  HIGH_BASE, 8'h00);

    // mbc3: zero bank, unknown select, out-of-range seconds, latch and read
    set_kind(KIND_MBC3);
    bus_op(FUNC_WRITE, CMD_BASE,  8'h80);
    bus_op(FUNC_WRITE, HIGH_BASE, RTC_SEL_LAST + 8'd1);
    bus_op(FUNC_WRITE, HIGH_BASE, RTC_SEL_FIRST);
    bus_op(FUNC_WRITE, RAM_BASE,  8'hFF);
    bus_op(FUNC_TICK,  16'h0000,  8'h00);
    bus_op(FUNC_WRITE, MODE_BASE, 8'h00);
    bus_op(FUNC_WRITE, MODE_BASE, 8'h01);
    bus_op(FUNC_READ,  RAM_BASE,  8'h00);

    // mbc5: bank 0, ninth bank bit, top ram bank
    set_kind(KIND_MBC5);
    bus_op(FUNC_WRITE, CMD_BASE,       8'h00);
    bus_op(FUNC_WRITE, MBC5_HIGH_BASE, 8'h01);
    bus_op(FUNC_READ,  HIGH_BASE,      8'h00);
    bus_op(FUNC_WRITE, HIGH_BASE,      8'h0F);
    bus_op(FUNC_READ,  16'hBFFF,       8'h00);

    // random phases over every mapper kind, some without any idling
    for (int p = 0; p < 11; p++) begin
      set_kind(phase_kinds[p]);
      gaps_on  = (p % 4 != 3);
      stall_on = (p % 4 != 3);
      start    = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if (phase_kinds[p] == KIND_MBC3 && $urandom_range(0, 7) == 0) clock_session();
        else rand_access(phase_kinds[p]);
        if (p == 2 && items_sent - start == PHASE_ITEMS / 2) wait_idle();
      end
    end

    wait_idle();
    if (model.errors == 0 && model.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== cartridge_bank_controller.f =====
sv/cbc_pkg.sv
sv/cbc_rtc.sv
sv/cbc_mapper.sv
sv/cartridge_bank_controller.sv
tb/tb_cartridge_bank_controller.sv
